// ===== design/cwp_pkg.sv =====
// Package for the cube wire-frame projector: formats, widths, sine coefficients,
// register indexes and the cube edge table. No dependencies.
package cwp_pkg;

   localparam int ANGLE_BITS = 12;
   localparam int FRAC_BITS  = 14;

   localparam int SIN_W   = FRAC_BITS + 2;
   localparam int COORD_W = FRAC_BITS + 3;
   localparam int DEN_W   = FRAC_BITS + 8;
   localparam int NUM_W   = FRAC_BITS + 18;
   localparam int DS_W    = 13;
   localparam int MA_W    = FRAC_BITS + 9;
   localparam int MB_W    = (SIN_W > DS_W + 1) ? SIN_W : DS_W + 1;
   localparam int PR_W    = MA_W + MB_W;
   localparam int PIX_W   = 9;
   localparam int EDGES   = 12;

   localparam logic [3:0] LAST_EDGE = 4'(EDGES - 1);

   localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

   // Odd-power coefficients of the quarter-wave sine polynomial, Q30.
   localparam logic signed [31:0] SIN_A1 = 32'sd1686629713;
   localparam logic signed [31:0] SIN_A3 = -32'sd693598666;
   localparam logic signed [31:0] SIN_A5 = 32'sd85569306;
   localparam logic signed [31:0] SIN_A7 = -32'sd5026995;
   localparam logic signed [31:0] SIN_A9 = 32'sd172272;

   localparam logic [1:0] REG_CENTRE_X      = 2'd0;
   localparam logic [1:0] REG_CENTRE_Y      = 2'd1;
   localparam logic [1:0] REG_SCALE         = 2'd2;
   localparam logic [1:0] REG_VIEW_DISTANCE = 2'd3;

   typedef logic signed [SIN_W-1:0]   sin_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PIX_W-1:0]   pix_type;

   typedef struct packed {
      coord_type z;
      pix_type   px;
      pix_type   py;
   } corner_type;

   localparam coord_type COORD_ONE = COORD_W'(1 << FRAC_BITS);

   function automatic logic [2:0] edge_first(input logic [3:0] idx);
      case (idx)
         4'd0, 4'd3, 4'd8:  edge_first = 3'd0 + 3'(idx == 4'd3) * 3'd3;
         default:           edge_first = 3'd0;
      endcase
      case (idx)
         4'd0:    edge_first = 3'd0;
         4'd1:    edge_first = 3'd1;
         4'd2:    edge_first = 3'd2;
         4'd3:    edge_first = 3'd3;
         4'd4:    edge_first = 3'd4;
         4'd5:    edge_first = 3'd5;
         4'd6:    edge_first = 3'd6;
         4'd7:    edge_first = 3'd7;
         4'd8:    edge_first = 3'd0;
         4'd9:    edge_first = 3'd1;
         4'd10:   edge_first = 3'd2;
         4'd11:   edge_first = 3'd3;
         default: edge_first = 3'd0;
      endcase
   endfunction

   function automatic logic [2:0] edge_second(input logic [3:0] idx);
      case (idx)
         4'd0:    edge_second = 3'd1;
         4'd1:    edge_second = 3'd2;
         4'd2:    edge_second = 3'd3;
         4'd3:    edge_second = 3'd0;
         4'd4:    edge_second = 3'd5;
         4'd5:    edge_second = 3'd6;
         4'd6:    edge_second = 3'd7;
         4'd7:    edge_second = 3'd4;
         4'd8:    edge_second = 3'd4;
         4'd9:    edge_second = 3'd5;
         4'd10:   edge_second = 3'd6;
         4'd11:   edge_second = 3'd7;
         default: edge_second = 3'd0;
      endcase
   endfunction

endpackage

// ===== design/cwp_sine.sv =====
// Iterative sine unit: quarter-wave odd polynomial evaluated by Horner steps
// on one registered 32x32 multiplier. Depends on cwp_pkg.
module cwp_sine
   import cwp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic                  done,
   output sin_type               value
);

   localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1 << (ANGLE_BITS - 2));
   localparam logic signed [31:0]    Q30_ONE = 32'sd1 <<< 30;

   logic                  busy_ff, absorb_ff, done_ff;
   logic [2:0]            k_ff;
   logic [1:0]            quad_ff;
   logic signed [31:0]    t_ff, t2_ff, r_ff;
   logic signed [63:0]    prod_ff;
   logic [ANGLE_BITS-2:0] phase;
   logic signed [31:0]    t_in, opa, opb, tr_prod, coef;
   logic signed [63:0]    biased;
   logic [30:0]           r_clamp, r_round;
   logic [FRAC_BITS:0]    mag;

   assign phase = angle[ANGLE_BITS-2] ? QUARTER - {1'b0, angle[ANGLE_BITS-3:0]}
                                      : {1'b0, angle[ANGLE_BITS-3:0]};
   assign t_in  = {1'b0, phase, {(32 - ANGLE_BITS){1'b0}}};

   assign opa = (k_ff == 3'd0) ? t_ff : r_ff;
   assign opb = (k_ff == 3'd0 || k_ff == 3'd5) ? t_ff : t2_ff;

   // Product back to Q30, truncated toward zero.
   assign biased  = prod_ff + (prod_ff[63] ? 64'sd1073741823 : 64'sd0);
   assign tr_prod = biased[61:30];

   always_comb begin
      case (k_ff)
         3'd1:    coef = SIN_A7;
         3'd2:    coef = SIN_A5;
         3'd3:    coef = SIN_A3;
         default: coef = SIN_A1;
      endcase
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff   <= 1'b0;
         absorb_ff <= 1'b0;
         k_ff      <= 3'd0;
      end else if (start) begin
         busy_ff   <= 1'b1;
         absorb_ff <= 1'b0;
         k_ff      <= 3'd0;
         t_ff      <= t_in;
         quad_ff   <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
      end else if (busy_ff) begin
         if (!absorb_ff) begin
            prod_ff   <= opa * opb;
            absorb_ff <= 1'b1;
         end else begin
            absorb_ff <= 1'b0;
            case (k_ff)
               3'd0:    begin
                  t2_ff <= tr_prod;
                  r_ff  <= SIN_A9;
               end
               3'd5:    r_ff <= tr_prod;
               default: r_ff <= coef + tr_prod;
            endcase
            if (k_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               k_ff <= k_ff + 3'd1;
            end
         end
      end
   end

   always_comb begin
      if (r_ff < 0) begin
         r_clamp = '0;
      end else if (r_ff > Q30_ONE) begin
         r_clamp = Q30_ONE[30:0];
      end else begin
         r_clamp = r_ff[30:0];
      end
   end

   assign r_round = r_clamp + 31'(1 << (29 - FRAC_BITS));
   assign mag     = r_round[30:30-FRAC_BITS];
   assign value   = quad_ff[1] ? -sin_type'({1'b0, mag}) : sin_type'({1'b0, mag});
   assign done    = done_ff;

endmodule

// ===== design/cwp_div.sv =====
// Restoring divider for the perspective divide, one quotient bit per cycle,
// truncating toward zero and saturating to the 9-bit screen range. Depends on cwp_pkg.
module cwp_div
   import cwp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    done,
   output pix_type                 quotient
);

   localparam int W = NUM_W + 1;

   logic                 busy_ff, done_ff, neg_ff, ovf_ff;
   logic [3:0]           cnt_ff;
   logic [W-1:0]         rem_ff, dsh_ff;
   logic [8:0]           qm_ff;
   logic [NUM_W-1:0]     mag;
   logic                 fits;
   logic [8:0]           m;
   logic signed [9:0]    q_wide;

   assign mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign fits = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 4'd0;
         neg_ff  <= num[NUM_W-1];
         ovf_ff  <= W'(mag) >= W'({den, 9'd0});
         rem_ff  <= W'(mag);
         dsh_ff  <= W'({den, 8'd0});
         qm_ff   <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         qm_ff  <= {qm_ff[7:0], fits};
         dsh_ff <= dsh_ff >> 1;
         if (cnt_ff == 4'd8) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff + 4'd1;
         end
      end
   end

   assign m = ovf_ff ? 9'h1FF : qm_ff;

   always_comb begin
      if (neg_ff) begin
         q_wide = (m > 9'd256) ? -10'sd256 : -$signed({1'b0, m});
      end else begin
         q_wide = (m > 9'd255) ? 10'sd255 : $signed({1'b0, m});
      end
   end

   assign quotient = PIX_W'(q_wide);
   assign done     = done_ff;

endmodule

// ===== design/cube_wireframe_projector.sv =====
// Top level of the cube wire-frame projector: sequencer, shared multiplier,
// corner memory and APB-style register port. Depends on cwp_pkg, cwp_sine, cwp_div.
//
// Usage. One transaction on the req_ channel carries three rotation angles in
// 4096ths of a turn. The block rotates the eight cube corners about X, then Y,
// then Z, projects them with a perspective divide and then emits twelve
// transactions on the rsp_ channel, one per cube edge in fixed table order.
// The last one carries rsp_last_edge. Each edge gives both projected endpoints
// and a dashed flag for edges whose midpoint lies behind the cube centre.
// From acceptance until the last edge is loaded into the output register the
// block runs the setup states S_PREP and S_PREP2, six sine evaluations on the
// polynomial unit, the rotations of each corner on the shared multiplier with
// the divides on the bit-serial divider, and two reads through the one read
// port of the corner memory for each edge. req_stall stays high for the whole
// frame; a new frame can be accepted once the last edge sits in the output
// register. While the receiver holds rsp_stall the output register keeps its
// edge and the sequencer waits. The user must see that registers are written
// only while no frame is in progress; the block itself does not enforce it.
// Reset is synchronous; it returns the registers to their defaults (centre 96,
// 32, scale 18, distance 8) and empties the output register.
module cube_wireframe_projector
   import cwp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ANGLE_BITS-1:0] req_angle_x,
   input  logic [ANGLE_BITS-1:0] req_angle_y,
   input  logic [ANGLE_BITS-1:0] req_angle_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_edge_index,
   output logic signed [8:0]     rsp_start_x,
   output logic signed [8:0]     rsp_start_y,
   output logic signed [8:0]     rsp_end_x,
   output logic signed [8:0]     rsp_end_y,
   output logic                  rsp_dashed,
   output logic                  rsp_last_edge,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PREP     = 4'd1;
   localparam logic [3:0] S_PREP2    = 4'd2;
   localparam logic [3:0] S_SIN_GO   = 4'd3;
   localparam logic [3:0] S_SIN_WAIT = 4'd4;
   localparam logic [3:0] S_CORNER   = 4'd5;
   localparam logic [3:0] S_MUL      = 4'd6;
   localparam logic [3:0] S_DIV_GO   = 4'd7;
   localparam logic [3:0] S_DIV_WAIT = 4'd8;
   localparam logic [3:0] S_EA       = 4'd9;
   localparam logic [3:0] S_EB       = 4'd10;
   localparam logic [3:0] S_EC       = 4'd11;

   // Configuration registers.
   logic [7:0] centre_x_ff, centre_y_ff;
   logic [5:0] scale_ff;
   logic [6:0] view_distance_ff;

   // Sequencer state.
   logic [3:0]            state_ff;
   logic [2:0]            sidx_ff, corner_ff, ph_ff, step_ff;
   logic [3:0]            edge_ff;
   logic [ANGLE_BITS-1:0] ax_ff, ay_ff, az_ff;
   sin_type               sin_ff [3];
   sin_type               cos_ff [3];
   coord_type             x_ff, y_ff, z_ff, res_ff;
   logic signed [PR_W-1:0] prod_ff, acc_ff;
   logic signed [NUM_W-1:0] num_ff;
   pix_type               px_ff;
   logic [DS_W-1:0]       ds_ff;

   // Corner memory and its registered read.
   corner_type            mem [8];
   corner_type            rdata_ff, hold_a_ff;
   logic [2:0]            raddr;

   // Output register.
   logic                  rsp_valid_ff, dashed_ff, last_ff;
   logic [3:0]            edge_index_ff;
   pix_type               sx_ff, sy_ff, ex_ff, ey_ff;

   logic                   accept, out_free, out_load;
   logic                   sin_start, sin_done, div_start, div_done;
   logic [ANGLE_BITS-1:0]  sin_angle, base_angle;
   sin_type                sin_value;
   pix_type                div_q;
   logic [1:0]             rix;
   coord_type              f_sel, g_sel, p_coord;
   sin_type                c_sel, s_sel;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [FRAC_BITS+8:0] den_raw;
   logic [DEN_W-1:0]       den;
   logic [7:0]             p_centre;
   coord_type              new_g;
   logic signed [COORD_W:0] z_sum;

   function automatic coord_type rnd(input logic signed [PR_W:0] v);
      logic signed [PR_W:0] w;
      w   = v + (PR_W+1)'(1 << (FRAC_BITS - 1));
      rnd = COORD_W'(w >>> FRAC_BITS);
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == S_EC) && out_free;

   // Register port.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff      <= 8'd96;
         centre_y_ff      <= 8'd32;
         scale_ff         <= 6'd18;
         view_distance_ff <= 7'd8;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_CENTRE_X:      centre_x_ff      <= pwdata[7:0];
            REG_CENTRE_Y:      centre_y_ff      <= pwdata[7:0];
            REG_SCALE:         scale_ff         <= pwdata[5:0];
            REG_VIEW_DISTANCE: view_distance_ff <= pwdata[6:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_CENTRE_X:      prdata = 32'(centre_x_ff);
         REG_CENTRE_Y:      prdata = 32'(centre_y_ff);
         REG_SCALE:         prdata = 32'(scale_ff);
         REG_VIEW_DISTANCE: prdata = 32'(view_distance_ff);
         default:           prdata = '0;
      endcase
   end

   // Sine unit: even index is the sine, odd index the cosine of one axis.
   always_comb begin
      case (sidx_ff[2:1])
         2'd0:    base_angle = ax_ff;
         2'd1:    base_angle = ay_ff;
         default: base_angle = az_ff;
      endcase
   end

   assign sin_angle = sidx_ff[0] ? base_angle + ANGLE_QUARTER : base_angle;
   assign sin_start = state_ff == S_SIN_GO;

   cwp_sine u_sine (
      .clock (clock),
      .reset (reset),
      .start (sin_start),
      .angle (sin_angle),
      .done  (sin_done),
      .value (sin_value)
   );

   // Each rotation maps a pair (f, g) to (f*c - g*s, f*s + g*c):
   // X uses (y, z), Y uses (z, x) and Z uses (x, y).
   assign rix = ph_ff[1:0];

   always_comb begin
      case (rix)
         2'd0:    begin
            f_sel = y_ff;
            g_sel = z_ff;
         end
         2'd1:    begin
            f_sel = z_ff;
            g_sel = x_ff;
         end
         default: begin
            f_sel = x_ff;
            g_sel = y_ff;
         end
      endcase
      if (rix == 2'd3) begin
         c_sel = cos_ff[0];
         s_sel = sin_ff[0];
      end else begin
         c_sel = cos_ff[rix];
         s_sel = sin_ff[rix];
      end
   end

   // Perspective denominator, forced to one when the viewer is at or behind the corner.
   assign den_raw = $signed({2'b00, view_distance_ff, {FRAC_BITS{1'b0}}})
                    + (FRAC_BITS+9)'(z_ff);
   assign den     = (den_raw <= 0) ? DEN_W'(1) : den_raw[DEN_W-1:0];

   assign p_coord  = (ph_ff == 3'd3) ? x_ff : y_ff;
   assign p_centre = (ph_ff == 3'd3) ? centre_x_ff : centre_y_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_PREP:  begin
            mul_a = MA_W'({1'b0, view_distance_ff});
            mul_b = MB_W'({1'b0, scale_ff});
         end
         S_MUL:   begin
            if (ph_ff < 3'd3) begin
               case (step_ff)
                  3'd0:    begin
                     mul_a = MA_W'(f_sel);
                     mul_b = MB_W'(c_sel);
                  end
                  3'd1:    begin
                     mul_a = MA_W'(g_sel);
                     mul_b = MB_W'(s_sel);
                  end
                  3'd2:    begin
                     mul_a = MA_W'(f_sel);
                     mul_b = MB_W'(s_sel);
                  end
                  default: begin
                     mul_a = MA_W'(g_sel);
                     mul_b = MB_W'(c_sel);
                  end
               endcase
            end else if (step_ff == 3'd0) begin
               mul_a = MA_W'(p_coord);
               mul_b = MB_W'({1'b0, ds_ff});
            end else begin
               mul_a = MA_W'({1'b0, den});
               mul_b = MB_W'({1'b0, p_centre});
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign new_g     = rnd((PR_W+1)'(acc_ff) + (PR_W+1)'(prod_ff));
   assign div_start = state_ff == S_DIV_GO;

   cwp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_ff),
      .den      (den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sidx_ff   <= 3'd0;
         corner_ff <= 3'd0;
         ph_ff     <= 3'd0;
         step_ff   <= 3'd0;
         edge_ff   <= 4'd0;
      end else begin
         case (state_ff)
            S_IDLE:     begin
               if (accept) begin
                  ax_ff    <= req_angle_x;
                  ay_ff    <= req_angle_y;
                  az_ff    <= req_angle_z;
                  state_ff <= S_PREP;
               end
            end
            S_PREP:     state_ff <= S_PREP2;
            S_PREP2:    begin
               ds_ff    <= prod_ff[DS_W-1:0];
               sidx_ff  <= 3'd0;
               state_ff <= S_SIN_GO;
            end
            S_SIN_GO:   state_ff <= S_SIN_WAIT;
            S_SIN_WAIT: begin
               if (sin_done) begin
                  if (sidx_ff[0]) begin
                     cos_ff[sidx_ff[2:1]] <= sin_value;
                  end else begin
                     sin_ff[sidx_ff[2:1]] <= sin_value;
                  end
                  if (sidx_ff == 3'd5) begin
                     corner_ff <= 3'd0;
                     state_ff  <= S_CORNER;
                  end else begin
                     sidx_ff  <= sidx_ff + 3'd1;
                     state_ff <= S_SIN_GO;
                  end
               end
            end
            S_CORNER:   begin
               x_ff     <= (corner_ff[0] ^ corner_ff[1]) ? COORD_ONE : -COORD_ONE;
               y_ff     <= corner_ff[1] ? COORD_ONE : -COORD_ONE;
               z_ff     <= corner_ff[2] ? COORD_ONE : -COORD_ONE;
               ph_ff    <= 3'd0;
               step_ff  <= 3'd0;
               state_ff <= S_MUL;
            end
            S_MUL:      begin
               if (ph_ff < 3'd3) begin
                  case (step_ff)
                     3'd0:    step_ff <= 3'd1;
                     3'd1:    begin
                        acc_ff  <= prod_ff;
                        step_ff <= 3'd2;
                     end
                     3'd2:    begin
                        res_ff  <= rnd((PR_W+1)'(acc_ff) - (PR_W+1)'(prod_ff));
                        step_ff <= 3'd3;
                     end
                     3'd3:    begin
                        acc_ff  <= prod_ff;
                        step_ff <= 3'd4;
                     end
                     default: begin
                        case (rix)
                           2'd0:    begin
                              y_ff <= res_ff;
                              z_ff <= new_g;
                           end
                           2'd1:    begin
                              z_ff <= res_ff;
                              x_ff <= new_g;
                           end
                           default: begin
                              x_ff <= res_ff;
                              y_ff <= new_g;
                           end
                        endcase
                        ph_ff   <= ph_ff + 3'd1;
                        step_ff <= 3'd0;
                     end
                  endcase
               end else begin
                  case (step_ff)
                     3'd0:    step_ff <= 3'd1;
                     3'd1:    begin
                        acc_ff  <= prod_ff;
                        step_ff <= 3'd2;
                     end
                     default: begin
                        num_ff   <= NUM_W'(acc_ff + prod_ff);
                        state_ff <= S_DIV_GO;
                     end
                  endcase
               end
            end
            S_DIV_GO:   state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_done) begin
                  if (ph_ff == 3'd3) begin
                     px_ff    <= div_q;
                     ph_ff    <= 3'd4;
                     step_ff  <= 3'd0;
                     state_ff <= S_MUL;
                  end else if (corner_ff == 3'd7) begin
                     edge_ff  <= 4'd0;
                     state_ff <= S_EA;
                  end else begin
                     corner_ff <= corner_ff + 3'd1;
                     state_ff  <= S_CORNER;
                  end
               end
            end
            S_EA:       state_ff <= S_EB;
            S_EB:       begin
               hold_a_ff <= rdata_ff;
               state_ff  <= S_EC;
            end
            S_EC:       begin
               if (out_free) begin
                  if (edge_ff == LAST_EDGE) begin
                     state_ff <= S_IDLE;
                  end else begin
                     edge_ff  <= edge_ff + 4'd1;
                     state_ff <= S_EA;
                  end
               end
            end
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   // The corner memory is written once per corner and read twice per edge;
   // the second address is held while the output is stalled.
   assign raddr = (state_ff == S_EA) ? edge_first(edge_ff) : edge_second(edge_ff);

   always_ff @(posedge clock) begin
      if (state_ff == S_DIV_WAIT && div_done && ph_ff == 3'd4) begin
         mem[corner_ff] <= '{z: z_ff, px: px_ff, py: div_q};
      end
      rdata_ff <= mem[raddr];
   end

   // Output register.
   assign z_sum = (COORD_W+1)'(hold_a_ff.z) + (COORD_W+1)'(rdata_ff.z);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         edge_index_ff <= edge_ff;
         sx_ff         <= hold_a_ff.px;
         sy_ff         <= hold_a_ff.py;
         ex_ff         <= rdata_ff.px;
         ey_ff         <= rdata_ff.py;
         dashed_ff     <= z_sum > 0;
         last_ff       <= edge_ff == LAST_EDGE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_index = edge_index_ff;
   assign rsp_start_x    = sx_ff;
   assign rsp_start_y    = sy_ff;
   assign rsp_end_x      = ex_ff;
   assign rsp_end_y      = ey_ff;
   assign rsp_dashed     = dashed_ff;
   assign rsp_last_edge  = last_ff;

`ifndef ASSERT_OFF
   a_sine_awaited: assert property (@(posedge clock) disable iff (reset)
      sin_done |-> state_ff == S_SIN_WAIT)
      else $error("sine result arrived while the sequencer was not waiting for it");

   a_div_awaited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider result arrived while the sequencer was not waiting for it");

   a_frame_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_PREP && req_stall)
      else $error("accepted frame did not start the sequencer");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (out_load && edge_ff == LAST_EDGE) |=> !req_stall && rsp_valid && rsp_last_edge)
      else $error("block not ready after the last edge of a frame was loaded");
`endif

endmodule

// ===== bench/tb_cube_wireframe_projector.sv =====
`timescale 1ns / 100ps
// Self-checking bench for cube_wireframe_projector: rotation and projection
// frames are predicted in-bench and checked edge by edge. Depends on cwp_pkg.
module tb_cube_wireframe_projector
   import cwp_pkg::*;
();

   // One edge of a projected frame, as the block should report it.
   typedef struct {
      logic [3:0] idx;
      pix_type    sx, sy, ex, ey;
      logic       dashed, last;
   } edge_rec_type;

   typedef struct {
      logic [ANGLE_BITS-1:0] ax, ay, az;
   } angle_set_type;

   localparam longint Q30 = longint'(1) << 30;
   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam int LIMIT_CYCLES = 1500000;

   // Corner pairs of each cube edge, in the order the block emits them.
   localparam int FIRST_CORNER  [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
   localparam int SECOND_CORNER [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall;
   logic [ANGLE_BITS-1:0] req_angle_x, req_angle_y, req_angle_z;
   logic rsp_valid, rsp_stall;
   logic [3:0] rsp_edge_index;
   logic signed [8:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic rsp_dashed, rsp_last_edge;
   logic psel, penable, pwrite, pready;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;

   cube_wireframe_projector dut (.*);

   always #5 clock = ~clock;

   // Mirror of the register file, updated whenever the bench writes one.
   logic [7:0] mir_centre_x = 8'd96;
   logic [7:0] mir_centre_y = 8'd32;
   logic [5:0] mir_scale    = 6'd18;
   logic [6:0] mir_distance = 7'd8;

   angle_set_type frames_to_send[$];
   edge_rec_type  edges_awaited[$];
   int error_count = 0;
   int edges_seen  = 0;
   int cycle_count = 0;

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Positive half of a sine wave over one quarter, Q1.14 result.
   function automatic longint quarter_sine(input longint p);
      longint t, t2, r;
      t  = p <<< (30 - (ANGLE_BITS - 2));
      t2 = t * t / Q30;
      r  = longint'(SIN_A9);
      r  = longint'(SIN_A7) + r * t2 / Q30;
      r  = longint'(SIN_A5) + r * t2 / Q30;
      r  = longint'(SIN_A3) + r * t2 / Q30;
      r  = longint'(SIN_A1) + r * t2 / Q30;
      r  = r * t / Q30;
      if (r < 0) r = 0;
      if (r > Q30) r = Q30;
      return (r + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   endfunction

   function automatic longint sine_of(input logic [ANGLE_BITS-1:0] a);
      logic [1:0] quadrant;
      longint phase, s;
      quadrant = a[ANGLE_BITS-1 -: 2];
      phase    = longint'(a[ANGLE_BITS-3:0]);
      s = quadrant[0] ? quarter_sine((longint'(1) << (ANGLE_BITS - 2)) - phase)
                      : quarter_sine(phase);
      return quadrant[1] ? -s : s;
   endfunction

   // Rounds half up when dropping the fraction bits.
   function automatic longint drop_frac(input longint v);
      return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic pix_type perspective(input longint c, input longint z,
                                           input longint centre);
      longint den, num, q;
      den = longint'(mir_distance) * ONE + z;
      if (den <= 0) den = 1;
      num = c * longint'(mir_distance) * longint'(mir_scale) + centre * den;
      q = num / den;
      if (q > 255) q = 255;
      if (q < -256) q = -256;
      return pix_type'(q);
   endfunction

   // Rotates the eight corners, projects them and queues one expectation per cube edge.
   task automatic predict_frame(input angle_set_type f);
      longint sx, cx, sy, cy, sz, cz, x, y, z, t;
      longint depth [8];
      pix_type px [8], py [8];
      edge_rec_type e;
      sx = sine_of(f.ax); cx = sine_of(f.ax + ANGLE_QUARTER);
      sy = sine_of(f.ay); cy = sine_of(f.ay + ANGLE_QUARTER);
      sz = sine_of(f.az); cz = sine_of(f.az + ANGLE_QUARTER);
      for (int i = 0; i < 8; i++) begin
         x = (i == 1 || i == 2 || i == 5 || i == 6) ? ONE : -ONE;
         y = ((i & 3) >= 2) ? ONE : -ONE;
         z = (i >= 4) ? ONE : -ONE;
         t = drop_frac(y * cx - z * sx);
         z = drop_frac(y * sx + z * cx);
         y = t;
         t = drop_frac(x * cy + z * sy);
         z = drop_frac(z * cy - x * sy);
         x = t;
         t = drop_frac(x * cz - y * sz);
         y = drop_frac(x * sz + y * cz);
         x = t;
         depth[i] = z;
         px[i] = perspective(x, z, longint'(mir_centre_x));
         py[i] = perspective(y, z, longint'(mir_centre_y));
      end
      for (int k = 0; k < EDGES; k++) begin
         e.idx    = 4'(k);
         e.sx     = px[FIRST_CORNER[k]];
         e.sy     = py[FIRST_CORNER[k]];
         e.ex     = px[SECOND_CORNER[k]];
         e.ey     = py[SECOND_CORNER[k]];
         e.dashed = (depth[FIRST_CORNER[k]] + depth[SECOND_CORNER[k]]) > 0;
         e.last   = (e.idx == LAST_EDGE);
         edges_awaited.push_back(e);
      end
   endtask

   // Sender. A transaction completes at a rising edge with valid high and
   // stall low; the prediction is made right there, with the current
   // register mirror, which only changes while the block is idle.
   logic frame_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      frame_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         predict_frame('{req_angle_x, req_angle_y, req_angle_z});
         frame_taken = 1'b1;
      end
   end

   // The driver offers frames in bursts of random length separated by
   // random gaps; a frame still waiting for acceptance is held unchanged.
   always @(negedge clock) begin
      angle_set_type f;
      if (!reset && (!req_valid || frame_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (frames_to_send.size() > 0) begin
            f = frames_to_send.pop_front();
            req_valid   <= 1'b1;
            req_angle_x <= f.ax;
            req_angle_y <= f.ay;
            req_angle_z <= f.az;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 6);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. The stall pattern switches among never stalling, light and
   // heavy stalling. Once, after a few frames, it holds off for a long
   // stretch while the sender keeps offering, so the block backs up.
   int mode_left = 0;
   int stall_mode = 0;
   int long_hold_left = 0;
   logic long_hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!long_hold_done && edges_seen >= 120) begin
            long_hold_done = 1'b1;
            long_hold_left = 2000;
         end
         if (mode_left == 0) begin
            mode_left  = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 2);
         end
         mode_left--;
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Monitor: every accepted edge is compared with the oldest expectation.
   always @(posedge clock) begin
      edge_rec_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         edges_seen++;
         if (edges_awaited.size() == 0) begin
            report($sformatf("unexpected edge %0d", rsp_edge_index));
         end else begin
            e = edges_awaited.pop_front();
            if (rsp_edge_index !== e.idx)
               report($sformatf("edge_index %0d, want %0d", rsp_edge_index, e.idx));
            if (rsp_start_x !== e.sx)
               report($sformatf("edge %0d start_x %0d, want %0d", e.idx, rsp_start_x, e.sx));
            if (rsp_start_y !== e.sy)
               report($sformatf("edge %0d start_y %0d, want %0d", e.idx, rsp_start_y, e.sy));
            if (rsp_end_x !== e.ex)
               report($sformatf("edge %0d end_x %0d, want %0d", e.idx, rsp_end_x, e.ex));
            if (rsp_end_y !== e.ey)
               report($sformatf("edge %0d end_y %0d, want %0d", e.idx, rsp_end_y, e.ey));
            if (rsp_dashed !== e.dashed)
               report($sformatf("edge %0d dashed %b, want %b", e.idx, rsp_dashed, e.dashed));
            if (rsp_last_edge !== e.last)
               report($sformatf("edge %0d last_edge %b, want %b", e.idx, rsp_last_edge,
                                e.last));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Register write in a setup and an access cycle, then a read back of the
   // same register to check that it holds what was written.
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {index, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (index)
         REG_CENTRE_X: mir_centre_x = value[7:0];
         REG_CENTRE_Y: mir_centre_y = value[7:0];
         REG_SCALE:    mir_scale    = value[5:0];
         default:      mir_distance = value[6:0];
      endcase
      @(negedge clock);
      psel <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_CENTRE_X: if (prdata[7:0] !== mir_centre_x) report("centre_x read back");
         REG_CENTRE_Y: if (prdata[7:0] !== mir_centre_y) report("centre_y read back");
         REG_SCALE:    if (prdata[5:0] !== mir_scale) report("scale read back");
         default:      if (prdata[6:0] !== mir_distance) report("view_distance read back");
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic configure(input logic [7:0] cx, input logic [7:0] cy,
                            input logic [5:0] sc, input logic [6:0] vd);
      write_register(REG_CENTRE_X, {24'hABCDEF, cx});
      write_register(REG_CENTRE_Y, 32'(cy));
      write_register(REG_SCALE, 32'(sc));
      write_register(REG_VIEW_DISTANCE, 32'(vd));
   endtask

   // Sender pauses here until every queued frame is accepted and every
   // expected edge has come back, plus a short settling pause.
   task automatic drain();
      while (frames_to_send.size() > 0 || req_valid || edges_awaited.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random angles, a share of them on or next to the quadrant boundaries.
   function automatic logic [ANGLE_BITS-1:0] pick_angle();
      if ($urandom_range(0, 4) == 0)
         return ANGLE_BITS'($urandom_range(0, 3) * 1024 + $urandom_range(0, 2) - 1);
      return ANGLE_BITS'($urandom_range(0, 4095));
   endfunction

   task automatic queue_random(input int count);
      repeat (count)
         frames_to_send.push_back('{pick_angle(), pick_angle(), pick_angle()});
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_angle_x = '0; req_angle_y = '0; req_angle_z = '0;
      rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed frames at the reset register values: zero rotation, the
      // largest angle, each quarter-turn boundary and single-axis turns.
      frames_to_send.push_back('{12'd0, 12'd0, 12'd0});
      frames_to_send.push_back('{12'd4095, 12'd4095, 12'd4095});
      frames_to_send.push_back('{12'd1024, 12'd0, 12'd0});
      frames_to_send.push_back('{12'd0, 12'd2048, 12'd0});
      frames_to_send.push_back('{12'd0, 12'd0, 12'd3072});
      frames_to_send.push_back('{12'd1023, 12'd1025, 12'd2047});
      frames_to_send.push_back('{12'd2049, 12'd3071, 12'd3073});
      frames_to_send.push_back('{12'd512, 12'd512, 12'd512});
      frames_to_send.push_back('{12'd2730, 12'd1365, 12'd0});
      frames_to_send.push_back('{12'hAAA, 12'h555, 12'hAAA});
      frames_to_send.push_back('{12'h555, 12'hAAA, 12'h555});
      frames_to_send.push_back('{12'd1, 12'd4094, 12'd256});
      drain();

      // Extremes of every register, including a zero scale and a viewer at
      // or inside the cube, where the projection saturates.
      configure(8'd255, 8'd0, 6'd63, 7'd2);
      frames_to_send.push_back('{12'd0, 12'd0, 12'd0});
      frames_to_send.push_back('{12'd512, 12'd512, 12'd0});
      queue_random(40);
      drain();
      configure(8'd0, 8'd255, 6'd1, 7'd64);
      queue_random(40);
      drain();
      configure(8'd128, 8'd64, 6'd0, 7'd0);
      frames_to_send.push_back('{12'd0, 12'd0, 12'd0});
      queue_random(15);
      drain();
      configure(8'd10, 8'd250, 6'd63, 7'd1);
      frames_to_send.push_back('{12'd0, 12'd0, 12'd0});
      queue_random(20);
      drain();
      configure(8'd200, 8'd100, 6'd40, 7'd127);
      queue_random(30);
      drain();
      configure(8'd96, 8'd32, 6'd18, 7'd8);
      queue_random(60);
      drain();

      // Remaining frames under random settings across the full field ranges.
      repeat (4) begin
         configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)));
         queue_random(25);
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/cwp_pkg.sv
design/cwp_sine.sv
design/cwp_div.sv
design/cube_wireframe_projector.sv
bench/tb_cube_wireframe_projector.sv
